@@ design/ibfsa_pkg.sv @@
package ibfsa_pkg;

    // Field widths of the item and result interfaces.
    localparam int ID_W       = 16;
    localparam int STEP_W     = 16;
    localparam int BYTES_W    = 40;
    localparam int ALIGNED_W  = 41;
    localparam int SUM_W      = 48;
    localparam int LG_W       = 5;
    localparam int SLOT_OUT_W = 6;
    localparam int STATUS_W   = 2;

    // Default slot table depth.
    localparam int MAX_SLOTS_DEF = 64;

    // Step range; steps above the top value saturate to it.
    localparam longint unsigned MAX_STEPS = 64'd65536;
    localparam logic [STEP_W-1:0] STEP_TOP =
        (MAX_STEPS - 64'd1 > 64'd65535) ? {STEP_W{1'b1}} : STEP_W'(MAX_STEPS - 64'd1);

    // Alignment after reset (log2 of bytes).
    localparam logic [LG_W-1:0] ALIGN_LG_RESET = LG_W'(6);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NAIVE_OVF  = 2'd1,
        ST_SLOT_OVF   = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    // One slot table entry as kept in the slot memory.
    typedef struct packed {
        logic [ALIGNED_W-1:0] size;
        logic [STEP_W-1:0]    free_after;
        logic                 pinned;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    // Control of the best-fit compare unit by the sequencer.
    typedef struct packed {
        logic clear;
        logic eval;
    } t_fit_ctl;

endpackage

@@ design/ibfsa_ram.sv @@
module ibfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ibfsa_fit_unit.sv @@
module ibfsa_fit_unit #(
    parameter int IDX_W = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ibfsa_pkg::t_fit_ctl             i_ctl,
    input  ibfsa_pkg::t_slot_entry          i_cand,
    input  logic [IDX_W-1:0]                i_cand_idx,
    input  logic [ibfsa_pkg::ALIGNED_W-1:0] i_aligned,
    input  logic [ibfsa_pkg::STEP_W-1:0]    i_first,
    output logic                            o_found,
    output logic [ibfsa_pkg::ALIGNED_W-1:0] o_best_size,
    output logic [IDX_W-1:0]                o_best_idx
);

    import ibfsa_pkg::*;

    logic                 r_found;
    logic [ALIGNED_W-1:0] r_best_size;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 w_better;

    // A candidate wins if it is free in time, large enough and strictly smaller
    // than the best so far, so ties stay with the lower index seen first.
    assign w_better = !i_cand.pinned && (i_cand.free_after < i_first) &&
                      (i_cand.size >= i_aligned) &&
                      (!r_found || (i_cand.size < r_best_size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.eval && w_better) begin
            r_found <= 1'b1;
        end
        if (i_ctl.eval && w_better) begin
            r_best_size <= i_cand.size;
            r_best_idx  <= i_cand_idx;
        end
    end

    assign o_found     = r_found;
    assign o_best_size = r_best_size;
    assign o_best_idx  = r_best_idx;

endmodule

@@ design/interval_best_fit_slot_assigner_top.sv @@
// Best-fit slot assigner for tensor live intervals. Pulse start with an item while busy
// is low; the item is taken at that edge. Exactly one result follows, shown for a single
// cycle with o_result_valid high; it cannot be held off, so the receiver must take it
// then. A non-dedicated item keeps the block busy longer the more slots are open, since
// the best-fit search reads one slot entry per cycle through the single read port of the
// slot memory; a dedicated item skips the search. A new item may be started in the cycle
// its predecessor's result is shown. The user must write the alignment register over the
// cfg channel only while no item is in flight; the block itself does not enforce this.
module interval_best_fit_slot_assigner_top #(
    parameter int MAX_SLOTS = ibfsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ibfsa_pkg::LG_W-1:0]       i_cfg_alignment_log2,
    // Item input.
    input  logic                             start,
    output logic                             busy,
    input  logic [ibfsa_pkg::ID_W-1:0]       i_tensor_tag,
    input  logic [ibfsa_pkg::STEP_W-1:0]     i_first_step,
    input  logic [ibfsa_pkg::STEP_W-1:0]     i_last_step,
    input  logic [ibfsa_pkg::BYTES_W-1:0]    i_tensor_bytes,
    input  logic                             i_dedicated,
    // Result output.
    output logic                             o_result_valid,
    output logic [ibfsa_pkg::ID_W-1:0]       o_placed_id,
    output logic [ibfsa_pkg::SLOT_OUT_W-1:0] o_slot_index,
    output logic [ibfsa_pkg::ALIGNED_W-1:0]  o_aligned_bytes,
    output logic                             o_reused,
    output logic [ibfsa_pkg::SUM_W-1:0]      o_slot_total,
    output logic [ibfsa_pkg::SUM_W-1:0]      o_naive_total,
    output logic [ibfsa_pkg::STATUS_W-1:0]   o_status
);

    import ibfsa_pkg::*;

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OPEN_W = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_CHECK,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state               r_state;
    logic [LG_W-1:0]      r_align_lg;
    logic [ID_W-1:0]      r_id;
    logic [STEP_W-1:0]    r_first;
    logic [STEP_W-1:0]    r_last;
    logic [BYTES_W-1:0]   r_bytes;
    logic                 r_ded;
    logic [ALIGNED_W-1:0] r_aligned;
    logic [SUM_W-1:0]     r_slot_sum;
    logic [SUM_W-1:0]     r_naive_sum;
    logic [SUM_W-1:0]     r_slot_add;
    logic [SUM_W-1:0]     r_naive_add;
    logic                 r_slot_ovf;
    logic                 r_naive_ovf;
    logic [OPEN_W-1:0]    r_open;
    logic [OPEN_W-1:0]    r_issue;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pend_idx;
    logic                 r_result_valid;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic                 r_out_reused;
    t_status              r_out_status;

    logic                 w_accept;
    logic                 w_issue;
    logic [ALIGNED_W-1:0] w_mask;
    logic [ALIGNED_W-1:0] w_aligned;
    logic [SUM_W:0]       w_naive_add;
    logic [SUM_W:0]       w_slot_add;
    logic [STEP_W-1:0]    w_first_clamped;
    logic [STEP_W-1:0]    w_last_clamped;
    logic [ENTRY_W-1:0]   w_rdata;
    t_slot_entry          w_cand;
    t_fit_ctl             w_fit_ctl;
    logic                 w_found;
    logic [ALIGNED_W-1:0] w_best_size;
    logic [IDX_W-1:0]     w_best_idx;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_slot_entry          w_wentry;
    logic                 w_take_reuse;
    logic                 w_take_new;
    t_status              w_status;
    logic [IDX_W-1:0]     w_slot;

    // Handshakes.
    assign busy        = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept    = start && !busy;
    assign o_cfg_ready = i_rst_n;

    // Steps beyond the supported range saturate.
    assign w_first_clamped = (i_first_step > STEP_TOP) ? STEP_TOP : i_first_step;
    assign w_last_clamped  = (i_last_step > STEP_TOP) ? STEP_TOP : i_last_step;

    // Round the size up to the configured power-of-two alignment.
    assign w_mask    = (ALIGNED_W'(1) << r_align_lg) - ALIGNED_W'(1);
    assign w_aligned = (ALIGNED_W'(r_bytes) + w_mask) & ~w_mask;

    // Candidate running totals; bit 48 flags an overflow.
    assign w_naive_add = {1'b0, r_naive_sum} + (SUM_W + 1)'(r_aligned);
    assign w_slot_add  = {1'b0, r_slot_sum} + (SUM_W + 1)'(r_aligned);

    // Scan issues one slot read per cycle until all open slots are read.
    assign w_issue = (r_state == S_SCAN) && (r_issue < r_open);

    ibfsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cand          = t_slot_entry'(w_rdata);
    assign w_fit_ctl.clear = w_accept;
    assign w_fit_ctl.eval  = r_pend;

    ibfsa_fit_unit #(
        .IDX_W (IDX_W)
    ) u_fit_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_fit_ctl),
        .i_cand      (w_cand),
        .i_cand_idx  (r_pend_idx),
        .i_aligned   (r_aligned),
        .i_first     (r_first),
        .o_found     (w_found),
        .o_best_size (w_best_size),
        .o_best_idx  (w_best_idx)
    );

    // Placement decision: overflow check first, then reuse, table full, slot overflow.
    always_comb begin
        w_status     = ST_OK;
        w_take_reuse = 1'b0;
        w_take_new   = 1'b0;
        w_slot       = '0;
        w_waddr      = '0;
        w_wentry     = '{size: r_aligned, free_after: r_last, pinned: r_ded};
        if (r_naive_ovf) begin
            w_status = ST_NAIVE_OVF;
        end else if (w_found) begin
            w_take_reuse = 1'b1;
            w_slot       = w_best_idx;
            w_waddr      = w_best_idx;
            w_wentry     = '{size: w_best_size, free_after: r_last, pinned: 1'b0};
        end else if (r_open == OPEN_W'(MAX_SLOTS)) begin
            w_status = ST_TABLE_FULL;
        end else if (r_slot_ovf) begin
            w_status = ST_SLOT_OVF;
        end else begin
            w_take_new = 1'b1;
            w_slot     = r_open[IDX_W-1:0];
            w_waddr    = r_open[IDX_W-1:0];
        end
    end

    assign w_we = (r_state == S_DECIDE) && (w_take_reuse || w_take_new);

    // Sequencer, running totals and registered result fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_align_lg     <= ALIGN_LG_RESET;
            r_open         <= '0;
            r_slot_sum     <= '0;
            r_naive_sum    <= '0;
            r_pend         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= (r_state == S_DECIDE);
            r_pend         <= w_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_align_lg <= i_cfg_alignment_log2;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= r_ded ? S_DECIDE : S_SCAN;
                end
                S_SCAN: begin
                    if (!w_issue) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    if (w_take_reuse || w_take_new) begin
                        r_naive_sum <= r_naive_add;
                    end
                    if (w_take_new) begin
                        r_slot_sum <= r_slot_add;
                        r_open     <= r_open + OPEN_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id    <= i_tensor_tag;
            r_first <= w_first_clamped;
            r_last  <= w_last_clamped;
            r_bytes <= i_tensor_bytes;
            r_ded   <= i_dedicated;
        end
        if (r_state == S_ALIGN) begin
            r_aligned <= w_aligned;
        end
        if (r_state == S_CHECK) begin
            r_naive_add <= w_naive_add[SUM_W-1:0];
            r_naive_ovf <= w_naive_add[SUM_W];
            r_slot_add  <= w_slot_add[SUM_W-1:0];
            r_slot_ovf  <= w_slot_add[SUM_W];
            r_issue     <= '0;
        end
        if (w_issue) begin
            r_issue    <= r_issue + OPEN_W'(1);
            r_pend_idx <= r_issue[IDX_W-1:0];
        end
        if (r_state == S_DECIDE) begin
            r_out_slot   <= SLOT_OUT_W'(w_slot);
            r_out_reused <= w_take_reuse;
            r_out_status <= w_status;
        end
    end

    // Result ports; id, size and totals stay put through the result cycle.
    assign o_result_valid  = r_result_valid;
    assign o_placed_id     = r_id;
    assign o_slot_index    = r_out_slot;
    assign o_aligned_bytes = r_aligned;
    assign o_reused        = r_out_reused;
    assign o_slot_total    = r_slot_sum;
    assign o_naive_total   = r_naive_sum;
    assign o_status        = r_out_status;

`ifndef SYNTHESIS
    // The count of open slots never passes the table depth.
    a_open_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_W'(MAX_SLOTS))
        else $error("slot count beyond table depth");

    // A result is shown only in the cycle after the decision.
    a_result_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_DECIDE))
        else $error("result strobe without a decision");

    // A reused slot is always reported without error.
    a_reuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_reused) |-> (o_status == ST_OK))
        else $error("reuse reported with an error status");

    // A failed placement leaves the running totals unchanged.
    a_error_keeps_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_status != ST_OK) |=>
            ($stable(r_slot_sum) && $stable(r_naive_sum) && $stable(r_open)))
        else $error("totals changed on a failed placement");
`endif

endmodule

@@ tb/tb_interval_best_fit_slot_assigner_top.sv @@
module tb_interval_best_fit_slot_assigner_top;
    import ibfsa_pkg::*;

    localparam int SLOT_CNT = MAX_SLOTS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int LAST_ROUTINE_STEP = 65534;
    localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_TOP = {BYTES_W{1'b1}};

    // One tensor live interval as sent to the block.
    typedef struct packed {
        logic [ID_W-1:0]    tensor_tag;
        logic [STEP_W-1:0]  first_step;
        logic [STEP_W-1:0]  last_step;
        logic [BYTES_W-1:0] tensor_bytes;
        logic               dedicated;
    } t_interval;

    // One placement as returned by the block.
    typedef struct packed {
        logic [ID_W-1:0]       placed_id;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ALIGNED_W-1:0]  aligned_bytes;
        logic                  reused;
        logic [SUM_W-1:0]      slot_total;
        logic [SUM_W-1:0]      naive_total;
        t_status               status;
    } t_placement;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [LG_W-1:0]       i_cfg_alignment_log2 = ALIGN_LG_RESET;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ID_W-1:0]       i_tensor_tag = '0;
    logic [STEP_W-1:0]     i_first_step = '0;
    logic [STEP_W-1:0]     i_last_step = '0;
    logic [BYTES_W-1:0]    i_tensor_bytes = '0;
    logic                  i_dedicated = 1'b0;
    logic                  o_result_valid;
    logic [ID_W-1:0]       o_placed_id;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic [ALIGNED_W-1:0]  o_aligned_bytes;
    logic                  o_reused;
    logic [SUM_W-1:0]      o_slot_total;
    logic [SUM_W-1:0]      o_naive_total;
    logic [STATUS_W-1:0]   o_status;

    // Slot table and totals as the block should hold them.
    logic [ALIGNED_W-1:0] pl_slot_size [SLOT_CNT];
    logic [STEP_W-1:0]    pl_free_after [SLOT_CNT];
    logic                 pl_pinned [SLOT_CNT];
    int                   pl_open = 0;
    logic [SUM_W-1:0]     pl_slot_sum = '0;
    logic [SUM_W-1:0]     pl_naive_sum = '0;
    logic [LG_W-1:0]      pl_align_lg = ALIGN_LG_RESET;

    t_interval  pending_intervals[$];
    t_placement expected_placements[$];
    t_interval  cur_interval = '0;
    int         mismatches = 0;
    int         step_cursor = 0;
    bit         idle_on = 1'b1;

    interval_best_fit_slot_assigner_top #(
        .MAX_SLOTS(SLOT_CNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_alignment_log2(i_cfg_alignment_log2),
        .start(start),
        .busy(busy),
        .i_tensor_tag(i_tensor_tag),
        .i_first_step(i_first_step),
        .i_last_step(i_last_step),
        .i_tensor_bytes(i_tensor_bytes),
        .i_dedicated(i_dedicated),
        .o_result_valid(o_result_valid),
        .o_placed_id(o_placed_id),
        .o_slot_index(o_slot_index),
        .o_aligned_bytes(o_aligned_bytes),
        .o_reused(o_reused),
        .o_slot_total(o_slot_total),
        .o_naive_total(o_naive_total),
        .o_status(o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Places one interval in the slot table copy and returns the placement it should get.
    function automatic t_placement place_interval(input t_interval it);
        t_placement           res;
        logic [63:0]          unit;
        logic [63:0]          aligned;
        logic [STEP_W-1:0]    first_s;
        logic [STEP_W-1:0]    last_s;
        logic [ALIGNED_W-1:0] best_size;
        int                   best_slot;
        bit                   fit;
        first_s = (it.first_step > STEP_TOP) ? STEP_TOP : it.first_step;
        last_s = (it.last_step > STEP_TOP) ? STEP_TOP : it.last_step;
        unit = 64'd1 << pl_align_lg;
        aligned = (64'(it.tensor_bytes) + unit - 64'd1) & ~(unit - 64'd1);
        fit = 1'b0;
        best_slot = 0;
        best_size = '0;
        res.placed_id = it.tensor_tag;
        res.aligned_bytes = aligned[ALIGNED_W-1:0];
        res.status = ST_OK;
        if (64'(pl_naive_sum) + aligned > 64'(SUM_TOP)) begin
            res.status = ST_NAIVE_OVF;
        end else begin
            // Best fit over open, unpinned slots that are free before the first step.
            if (!it.dedicated) begin
                for (int s = 0; s < pl_open; s++) begin
                    if (!pl_pinned[s] && pl_free_after[s] < first_s &&
                        64'(pl_slot_size[s]) >= aligned &&
                        (!fit || pl_slot_size[s] < best_size)) begin
                        fit = 1'b1;
                        best_size = pl_slot_size[s];
                        best_slot = s;
                    end
                end
            end
            if (fit) begin
                pl_free_after[best_slot] = last_s;
                pl_naive_sum = pl_naive_sum + aligned[SUM_W-1:0];
            end else if (pl_open >= SLOT_CNT) begin
                res.status = ST_TABLE_FULL;
            end else if (64'(pl_slot_sum) + aligned > 64'(SUM_TOP)) begin
                res.status = ST_SLOT_OVF;
            end else begin
                best_slot = pl_open;
                pl_slot_size[best_slot] = aligned[ALIGNED_W-1:0];
                pl_free_after[best_slot] = last_s;
                pl_pinned[best_slot] = it.dedicated;
                pl_open++;
                pl_slot_sum = pl_slot_sum + aligned[SUM_W-1:0];
                pl_naive_sum = pl_naive_sum + aligned[SUM_W-1:0];
            end
        end
        // An error leaves the table alone and reports slot zero, not reused.
        if (res.status != ST_OK) begin
            best_slot = 0;
            fit = 1'b0;
        end
        res.slot_index = SLOT_OUT_W'(best_slot);
        res.reused = fit;
        res.slot_total = pl_slot_sum;
        res.naive_total = pl_naive_sum;
        return res;
    endfunction

    task automatic queue_interval(input logic [ID_W-1:0] id, input logic [STEP_W-1:0] first_s,
                                  input logic [STEP_W-1:0] last_s,
                                  input logic [BYTES_W-1:0] bytes, input logic ded);
        t_interval it;
        it = '{id, first_s, last_s, bytes, ded};
        pending_intervals.insert(pending_intervals.size(), it);
    endtask

    // Waits until every queued interval has been placed and its placement has come back.
    task automatic wait_drained();
        while (pending_intervals.size() != 0 || expected_placements.size() != 0 || start)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_alignment(input logic [LG_W-1:0] lg);
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_alignment_log2 <= lg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Sorted runs of intervals with random content, plus a few stray and reversed ones.
    task automatic add_random_intervals(input int count);
        t_interval it;
        int        run_left;
        int        pick;
        int        first_s;
        int        last_s;
        run_left = 0;
        repeat (count) begin
            it.dedicated = 1'b0;
            if (run_left == 0) begin
                run_left = $urandom_range(20, 60);
                it.dedicated = ($urandom_range(3) == 0);
            end
            run_left--;
            it.tensor_tag = ID_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 2) begin
                first_s = $urandom_range(0, 65535);
                last_s = $urandom_range(0, LAST_ROUTINE_STEP);
            end else begin
                first_s = step_cursor;
                if (pick < 5) begin
                    last_s = $urandom_range(0, first_s);
                end else begin
                    last_s = first_s + $urandom_range(0, 300);
                    if (last_s > LAST_ROUTINE_STEP) last_s = LAST_ROUTINE_STEP;
                end
                step_cursor = step_cursor + $urandom_range(0, 40);
                if (step_cursor > 65000) step_cursor = 65000;
            end
            it.first_step = STEP_W'(first_s);
            it.last_step = STEP_W'(last_s);
            pick = $urandom_range(99);
            if (pick < 60) begin
                it.tensor_bytes = BYTES_W'($urandom_range(0, 4096));
            end else if (pick < 90) begin
                it.tensor_bytes = BYTES_W'($urandom_range(0, 1 << 20));
            end else if (pick < 98) begin
                it.tensor_bytes = BYTES_W'($urandom);
            end else begin
                it.tensor_bytes = BYTES_W'({$urandom, $urandom});
            end
            pending_intervals.insert(pending_intervals.size(), it);
        end
    endtask

    // Sender: presents the next pending interval and predicts each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_placements.insert(expected_placements.size(),
                                           place_interval(cur_interval));
            end
            if (!start || !busy) begin
                if (pending_intervals.size() != 0 &&
                    !(idle_on && $urandom_range(99) < 27)) begin
                    cur_interval = pending_intervals.pop_front();
                    start <= 1'b1;
                    i_tensor_tag <= cur_interval.tensor_tag;
                    i_first_step <= cur_interval.first_step;
                    i_last_step <= cur_interval.last_step;
                    i_tensor_bytes <= cur_interval.tensor_bytes;
                    i_dedicated <= cur_interval.dedicated;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Alignment as the block holds it after each configuration transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            pl_align_lg <= i_cfg_alignment_log2;
        end
    end

    // Receiver: checks every placement against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_placement got;
        t_placement want;
        if (i_rst_n && o_result_valid) begin
            got.placed_id = o_placed_id;
            got.slot_index = o_slot_index;
            got.aligned_bytes = o_aligned_bytes;
            got.reused = o_reused;
            got.slot_total = o_slot_total;
            got.naive_total = o_naive_total;
            got.status = t_status'(o_status);
            if (expected_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("placement for id %h with none pending", o_placed_id);
            end else begin
                want = expected_placements.pop_front();
                if (got.placed_id !== want.placed_id || got.slot_index !== want.slot_index ||
                    got.aligned_bytes !== want.aligned_bytes ||
                    got.reused !== want.reused || got.slot_total !== want.slot_total ||
                    got.naive_total !== want.naive_total || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("placement mismatch, expected id %h slot %0d bytes %h reused %0d",
                                 want.placed_id, want.slot_index, want.aligned_bytes,
                                 want.reused);
                        $display("  slot total %h naive total %h status %0d",
                                 want.slot_total, want.naive_total, want.status);
                        $display("  got id %h slot %0d bytes %h reused %0d",
                                 got.placed_id, got.slot_index, got.aligned_bytes, got.reused);
                        $display("  slot total %h naive total %h status %0d",
                                 got.slot_total, got.naive_total, got.status);
                    end
                end
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pinned slots first: an empty tensor with the widest range, then the step extremes.
        queue_interval(16'hFFFF, 16'd0, 16'hFFFF, '0, 1'b1);
        queue_interval(16'h0000, 16'hFFFF, 16'd0, 40'd1, 1'b1);
        // The largest tensor opens a full-size slot that stays busy through this part.
        queue_interval(16'h0001, 16'd0, 16'd1000, BYTES_TOP, 1'b0);
        queue_interval(16'h0002, 16'd1, 16'd5, 40'd64, 1'b0);
        queue_interval(16'h0003, 16'd2, 16'd9, 40'd100, 1'b0);
        queue_interval(16'h0004, 16'd3, 16'd9, 40'd120, 1'b0);
        // Two equal candidates: the lower slot wins.
        queue_interval(16'h0005, 16'd10, 16'd12, 40'd65, 1'b0);
        // The smallest fitting slot wins over a larger free one.
        queue_interval(16'h0006, 16'd10, 16'd10, 40'd1, 1'b0);
        // Zero bytes still takes a slot; a slot freed at the first step itself is not free.
        queue_interval(16'h0007, 16'd11, 16'd11, 40'd0, 1'b0);
        queue_interval(16'h0008, 16'd11, 16'd11, 40'd1, 1'b0);
        // A dedicated tensor opens its own slot although one would fit.
        queue_interval(16'h0009, 16'd20, 16'd21, 40'd1, 1'b1);
        // The last step below the first; an earlier tensor may then reuse the slot.
        queue_interval(16'h000A, 16'd30, 16'd2, 40'd64, 1'b0);
        queue_interval(16'h000B, 16'd3, 16'd40, 40'd64, 1'b0);
        // Alignment extremes: none at all, then the widest the register holds.
        write_alignment('0);
        queue_interval(16'h5555, 16'd41, 16'd45, 40'h55_5555_5555, 1'b0);
        queue_interval(16'hAAAA, 16'd41, 16'd45, 40'hAA_AAAA_AAAA, 1'b0);
        write_alignment({LG_W{1'b1}});
        queue_interval(16'h000C, 16'd46, 16'd48, 40'd1, 1'b0);
        queue_interval(16'h000D, 16'd46, 16'd48, BYTES_TOP, 1'b0);

        // Random runs over several alignments.
        step_cursor = 50;
        write_alignment(LG_W'(20));
        add_random_intervals(200);
        write_alignment('0);
        add_random_intervals(250);
        // A long stretch with no idling on the sender.
        write_alignment(LG_W'(3));
        idle_on = 1'b0;
        add_random_intervals(200);
        wait_drained();
        idle_on = 1'b1;
        write_alignment({LG_W{1'b1}});
        add_random_intervals(60);
        write_alignment(LG_W'($urandom_range(1, 30)));
        add_random_intervals(250);
        // The sender holds off mid-phase until every placement has come back.
        write_alignment(LG_W'(12));
        add_random_intervals(150);
        wait_drained();
        add_random_intervals(150);
        write_alignment(ALIGN_LG_RESET);
        add_random_intervals(100);

        // Full-size tensors keep reusing a full-size slot until the naive total overflows.
        write_alignment(LG_W'(20));
        repeat (270) queue_interval(ID_W'($urandom), STEP_TOP, 16'd0, BYTES_TOP, 1'b0);
        // Pinned tensors fill the table; after that new slots are refused.
        repeat (66) begin
            queue_interval(ID_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                           BYTES_W'($urandom_range(1, 256)), 1'b1);
        end
        // Nothing is free before step zero, so these need a new slot as well.
        repeat (4) queue_interval(ID_W'($urandom), 16'd0, 16'd0,
                                  BYTES_W'($urandom_range(0, 64)), 1'b0);
        // Naive overflow takes precedence over a full table.
        queue_interval(16'h7FFF, 16'd0, 16'd0, BYTES_TOP, 1'b1);

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && expected_placements.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ibfsa_pkg.sv
design/ibfsa_ram.sv
design/ibfsa_fit_unit.sv
design/interval_best_fit_slot_assigner_top.sv
tb/tb_interval_best_fit_slot_assigner_top.sv
